FILE: sv/schroeder_allpass_stage_top_defines.svh
// Assertion macros for the Schroeder allpass stage.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SCHROEDER_ALLPASS_STAGE_TOP_DEFINES_SVH
`define SCHROEDER_ALLPASS_STAGE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SAP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sap_pkg.sv
// Shared types and constants for the Schroeder allpass stage.
// No dependencies; imported by schroeder_allpass_stage_top.
package sap_pkg;

   localparam int COEF_BITS  = 24;
   localparam int COEF_FRAC  = 23;
   localparam int LEN_BITS   = 11;
   localparam int LEN_MIN    = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_COEF_B0      = 2'd0,
      REG_COEF_B1      = 2'd1,
      REG_COEF_A1      = 2'd2,
      REG_DELAY_LENGTH = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef logic signed [COEF_BITS-1:0] coef_type;

endpackage

FILE: sv/schroeder_allpass_stage_top.sv
// Top level of the Schroeder allpass stage: history memory, tap sequencer, MAC, output queue.
// Depends on sap_pkg and schroeder_allpass_stage_top_defines.svh.
//
// One stage of a frequency-dependent Schroeder allpass. Each filter beat on req
// (req_tuser = 0) yields one beat on rsp holding
//    y = b1*x + b0*x[n-1] + a1*x[n-L+1] + x[n-L] - a1*y[n-1] - b0*y[n-L+1] - b1*y[n-L],
// rounded half-up from Q1.23 and saturated to SAMPLE_BITS, with rsp_tuser flagging a clip.
// A clear beat (req_tuser = 1) gives no result; it zeroes both histories and the position.
// Input and output histories share one memory word per position, so three reads
// (tap L, tap L-1, tap one) fetch all six taps. A new beat is taken only after the previous
// one's three read slots on the memory read port plus one spare slot, so that the previous
// beat's write-back is visible through the forwarding register before the short taps
// are read. A result passes the tap sequencer, the memory read register, the product
// registers, the accumulator and the output queue before it is valid on rsp. Up to 4
// results may wait in the output queue; req_tready drops when 4 are outstanding. After
// reset, and after a clear beat once in-flight beats have drained, a sweep zeroes all
// MAX_LEN memory entries one entry per cycle, during which req_tready is low; CSR writes
// are taken at all times. CSRs (byte address 4*index): 0 coef_b0, 1 coef_b1, 2 coef_a1 (Q1.23 signed), 3 delay_length.
// Write CSRs only while no beat is in flight.
`include "schroeder_allpass_stage_top_defines.svh"

module schroeder_allpass_stage_top #(
   parameter int MAX_LEN     = 1024,
   parameter int SAMPLE_BITS = 24,
   localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [DATA_W-1:0]                    req_tdata,   // [SAMPLE_BITS-1:0] sample_in
   input  logic                                 req_tuser,   // [0] operation

   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [DATA_W-1:0]                    rsp_tdata,   // [SAMPLE_BITS-1:0] sample_out
   output logic                                 rsp_tuser,   // [0] saturated

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sap_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sap_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sap_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import sap_pkg::*;

   localparam int PTR_W   = $clog2(MAX_LEN);
   localparam int LENV_W  = PTR_W + 1;
   localparam int CMP_W   = (LEN_BITS > LENV_W) ? LEN_BITS : LENV_W;
   localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W   = PROD_W + 3;
   localparam int YW      = ACC_W - COEF_FRAC;
   localparam int WORD_W  = 2 * SAMPLE_BITS;
   localparam int QDEPTH  = 4;
   localparam int Q_PTR_W = 2;
   localparam int CNT_W   = 3;
   localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(MAX_LEN - 1);

   // Read slot of a beat: which tap pair is fetched, then a spare slot.
   typedef enum logic [1:0] {
      PH_TAP_L    = 2'd0,
      PH_TAP_NEXT = 2'd1,
      PH_TAP_PREV = 2'd2,
      PH_GAP      = 2'd3
   } phase_type;

   // ---------------------------------------------------------------- CSRs
   coef_type             coef_b0_ff, coef_b1_ff, coef_a1_ff;
   logic [LEN_BITS-1:0]  dlen_ff;
   logic                 csr_we;
   reg_index_type        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= '0;
         coef_b1_ff <= '0;
         coef_a1_ff <= '0;
         dlen_ff    <= LEN_BITS'(LEN_MIN);
      end else if (csr_we) begin
         case (csr_idx)
            REG_COEF_B0:      coef_b0_ff <= coef_type'(csr_pwdata[COEF_BITS-1:0]);
            REG_COEF_B1:      coef_b1_ff <= coef_type'(csr_pwdata[COEF_BITS-1:0]);
            REG_COEF_A1:      coef_a1_ff <= coef_type'(csr_pwdata[COEF_BITS-1:0]);
            REG_DELAY_LENGTH: dlen_ff    <= csr_pwdata[LEN_BITS-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_COEF_B0:      csr_prdata = CSR_DATA_W'(coef_b0_ff[COEF_BITS-1:0]);
         REG_COEF_B1:      csr_prdata = CSR_DATA_W'(coef_b1_ff[COEF_BITS-1:0]);
         REG_COEF_A1:      csr_prdata = CSR_DATA_W'(coef_a1_ff[COEF_BITS-1:0]);
         REG_DELAY_LENGTH: csr_prdata = CSR_DATA_W'(dlen_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------- length and position
   logic [CMP_W-1:0]  dlen_ext;
   logic [LENV_W-1:0] len_eff;
   logic [PTR_W-1:0]  len_last, pos_cur, pos_prev, pos_next;
   logic [PTR_W-1:0]  wp_ff;

   // Clamp the length into 2..MAX_LEN; restart at 0 if the position ran past it.
   always_comb begin
      dlen_ext = CMP_W'(dlen_ff);
      if (dlen_ext < CMP_W'(LEN_MIN)) begin
         len_eff = LENV_W'(LEN_MIN);
      end else if (dlen_ext > CMP_W'(MAX_LEN)) begin
         len_eff = LENV_W'(MAX_LEN);
      end else begin
         len_eff = LENV_W'(dlen_ext);
      end
      len_last = PTR_W'(len_eff - LENV_W'(1));
      pos_cur  = (LENV_W'(wp_ff) >= len_eff) ? '0 : wp_ff;
      pos_prev = (pos_cur == '0) ? len_last : pos_cur - PTR_W'(1);
      pos_next = (pos_cur == len_last) ? '0 : pos_cur + PTR_W'(1);
   end

   // ------------------------------------------------------ input handshake
   logic             iss_active_ff;
   phase_type        iss_phase_ff;
   logic             rd_valid_ff, mul_valid_ff, acc_done_ff;
   logic             clr_active_ff, clr_pend_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             pipe_empty, issue_free, req_acc, op_filter, op_clear, rsp_pop;

   assign pipe_empty = !iss_active_ff && !rd_valid_ff && !mul_valid_ff && !acc_done_ff;
   assign issue_free = !iss_active_ff || (iss_phase_ff == PH_GAP);
   assign req_tready = !clr_active_ff && !clr_pend_ff && issue_free &&
                       (cnt_ff < CNT_W'(QDEPTH));
   assign req_acc    = req_tvalid && req_tready;
   assign op_filter  = req_acc && (op_type'(req_tuser) == OP_FILTER);
   assign op_clear   = req_acc && (op_type'(req_tuser) == OP_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (op_clear) begin
         wp_ff <= '0;
      end else if (op_filter) begin
         wp_ff <= pos_next;
      end
   end

   // ------------------------------------------------------- tap sequencer
   logic [PTR_W-1:0]              iss_p_ff, iss_next_ff, iss_prev_ff;
   logic signed [SAMPLE_BITS-1:0] iss_x_ff;
   logic                          rd_en;
   logic [PTR_W-1:0]              rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_active_ff <= 1'b0;
         iss_phase_ff  <= PH_TAP_L;
      end else if (op_filter) begin
         iss_active_ff <= 1'b1;
         iss_phase_ff  <= PH_TAP_L;
      end else if (iss_active_ff) begin
         case (iss_phase_ff)
            PH_TAP_L:    iss_phase_ff <= PH_TAP_NEXT;
            PH_TAP_NEXT: iss_phase_ff <= PH_TAP_PREV;
            PH_TAP_PREV: iss_phase_ff <= PH_GAP;
            default: begin
               iss_phase_ff  <= PH_TAP_L;
               iss_active_ff <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (op_filter) begin
         iss_p_ff    <= pos_cur;
         iss_next_ff <= pos_next;
         iss_prev_ff <= pos_prev;
         iss_x_ff    <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   // Long tap first, short taps last: they may hit the previous beat's write.
   assign rd_en = iss_active_ff && (iss_phase_ff != PH_GAP);
   always_comb begin
      case (iss_phase_ff)
         PH_TAP_L:    rd_addr = iss_p_ff;
         PH_TAP_NEXT: rd_addr = iss_next_ff;
         default:     rd_addr = iss_prev_ff;
      endcase
   end

   // ------------------------------------------------------ history memory
   // Word layout: {output sample, input sample}.
   logic [WORD_W-1:0] hist_mem [MAX_LEN];
   logic [WORD_W-1:0] mem_q_ff;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_wa;
   logic [WORD_W-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= hist_mem[rd_addr];
      end
   end

   // ----------------------------------------------------- read return
   phase_type                     rd_phase_ff;
   logic [PTR_W-1:0]              rd_addr_ff, rd_p_ff;
   logic signed [SAMPLE_BITS-1:0] rd_x_ff;
   logic                          last_wr_valid_ff;
   logic [PTR_W-1:0]              last_wr_addr_ff;
   logic [WORD_W-1:0]             last_wr_data_ff;
   logic [WORD_W-1:0]             rd_word;
   logic signed [SAMPLE_BITS-1:0] tap_x, tap_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_phase_ff <= iss_phase_ff;
         rd_addr_ff  <= rd_addr;
         rd_p_ff     <= iss_p_ff;
         rd_x_ff     <= iss_x_ff;
      end
   end

   // Forward the most recent write over the memory's stale read data.
   assign rd_word = (last_wr_valid_ff && (last_wr_addr_ff == rd_addr_ff)) ?
                    last_wr_data_ff : mem_q_ff;
   assign tap_x   = rd_word[SAMPLE_BITS-1:0];
   assign tap_y   = rd_word[WORD_W-1:SAMPLE_BITS];

   // --------------------------------------------------------- multipliers
   coef_type                      a_coef, b_coef;
   logic signed [SAMPLE_BITS-1:0] a_smp, b_smp;
   phase_type                     mul_phase_ff;
   logic signed [PROD_W-1:0]      mul_a_ff, mul_b_ff;
   logic signed [SAMPLE_BITS-1:0] mul_xp_ff, mul_x_ff;
   logic [PTR_W-1:0]              mul_p_ff;

   // Product a is added in the short-tap slots and subtracted in the long-tap slot.
   always_comb begin
      case (rd_phase_ff)
         PH_TAP_L: begin
            a_coef = coef_b1_ff;  a_smp = tap_y;
            b_coef = coef_b1_ff;  b_smp = rd_x_ff;
         end
         PH_TAP_NEXT: begin
            a_coef = coef_a1_ff;  a_smp = tap_x;
            b_coef = coef_b0_ff;  b_smp = tap_y;
         end
         default: begin
            a_coef = coef_b0_ff;  a_smp = tap_x;
            b_coef = coef_a1_ff;  b_smp = tap_y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         mul_phase_ff <= rd_phase_ff;
         mul_a_ff     <= a_coef * a_smp;
         mul_b_ff     <= b_coef * b_smp;
         mul_xp_ff    <= tap_x;
         mul_x_ff     <= rd_x_ff;
         mul_p_ff     <= rd_p_ff;
      end
   end

   // ---------------------------------------------------------- accumulator
   logic signed [ACC_W-1:0]       acc_ff, acc_in, xp_term;
   logic signed [SAMPLE_BITS-1:0] acc_x_ff;
   logic [PTR_W-1:0]              acc_p_ff;

   always_comb begin
      xp_term = ACC_W'(mul_xp_ff) <<< COEF_FRAC;
      if (mul_phase_ff == PH_TAP_L) begin
         acc_in = xp_term + ACC_W'(mul_b_ff) - ACC_W'(mul_a_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(mul_a_ff) - ACC_W'(mul_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_done_ff <= 1'b0;
      end else begin
         acc_done_ff <= mul_valid_ff && (mul_phase_ff == PH_TAP_PREV);
      end
   end

   always_ff @(posedge clock) begin
      if (mul_valid_ff) begin
         acc_ff   <= acc_in;
         acc_x_ff <= mul_x_ff;
         acc_p_ff <= mul_p_ff;
      end
   end

   // ------------------------------------------------- round and saturate
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [YW-1:0]     y_wide;
   logic                     sat_hi, sat_lo, y_sat;
   logic [SAMPLE_BITS-1:0]   y_res;

   always_comb begin
      acc_rnd = acc_ff + (ACC_W'(1) <<< (COEF_FRAC - 1));
      y_wide  = acc_rnd[ACC_W-1:COEF_FRAC];
      sat_hi  = !y_wide[YW-1] && (y_wide[YW-2:SAMPLE_BITS-1] != '0);
      sat_lo  = y_wide[YW-1] && (y_wide[YW-2:SAMPLE_BITS-1] != '1);
      y_sat   = sat_hi || sat_lo;
      if (sat_hi) begin
         y_res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (sat_lo) begin
         y_res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         y_res = y_wide[SAMPLE_BITS-1:0];
      end
   end

   // ------------------------------------------- write-back and clear sweep
   logic [PTR_W-1:0] clr_addr_ff;

   assign mem_we = acc_done_ff || clr_active_ff;
   assign mem_wa = clr_active_ff ? clr_addr_ff : acc_p_ff;
   assign mem_wd = clr_active_ff ? '0 : {y_res, acc_x_ff};

   // Hold a clear until in-flight beats have written back, then sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_pend_ff   <= 1'b0;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + PTR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_ff <= 1'b0;
         end
      end else if (clr_pend_ff && pipe_empty) begin
         clr_pend_ff   <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (op_clear) begin
         clr_pend_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_valid_ff <= 1'b0;
      end else if (clr_active_ff) begin
         last_wr_valid_ff <= 1'b0;
      end else if (acc_done_ff) begin
         last_wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_done_ff) begin
         last_wr_addr_ff <= acc_p_ff;
         last_wr_data_ff <= {y_res, acc_x_ff};
      end
   end

   // -------------------------------------------------------- output queue
   logic [SAMPLE_BITS:0] q_data_ff [QDEPTH];
   logic [Q_PTR_W-1:0]   q_wp_ff, q_rp_ff;
   logic [CNT_W-1:0]     q_count_ff;
   logic [SAMPLE_BITS:0] q_head;

   assign q_head     = q_data_ff[q_rp_ff];
   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tdata  = DATA_W'(q_head[SAMPLE_BITS-1:0]);
   assign rsp_tuser  = q_head[SAMPLE_BITS];
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (acc_done_ff) begin
         q_data_ff[q_wp_ff] <= {y_sat, y_res};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff    <= '0;
         q_rp_ff    <= '0;
         q_count_ff <= '0;
         cnt_ff     <= '0;
      end else begin
         if (acc_done_ff) begin
            q_wp_ff <= q_wp_ff + Q_PTR_W'(1);
         end
         if (rsp_pop) begin
            q_rp_ff <= q_rp_ff + Q_PTR_W'(1);
         end
         q_count_ff <= q_count_ff + CNT_W'(acc_done_ff) - CNT_W'(rsp_pop);
         cnt_ff     <= cnt_ff + CNT_W'(op_filter) - CNT_W'(rsp_pop);
      end
   end

   // ----------------------------------------------------------- assertions
   `SAP_ASSERT_SAME(a_queue_within_credit, clock, reset, 1'b1, q_count_ff <= cnt_ff,
      "output queue holds more results than were accepted")
   `SAP_ASSERT_SAME(a_sweep_pipe_idle, clock, reset, clr_active_ff,
      !iss_active_ff && !rd_valid_ff && !mul_valid_ff && !acc_done_ff,
      "memory clear sweep overlaps an in-flight beat")
   `SAP_ASSERT_NEXT(a_result_queued, clock, reset, acc_done_ff, q_count_ff != '0,
      "finished result did not reach the output queue")
   `SAP_ASSERT_NEXT(a_filter_issues, clock, reset, op_filter,
      iss_active_ff && (iss_phase_ff == PH_TAP_L),
      "accepted filter beat did not start its tap reads")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for schroeder_allpass_stage_top: a sample-by-sample output predictor,
// directed and random sample streams, and APB register setup between phases.
// Depends on sap_pkg and the RTL of schroeder_allpass_stage_top.

class allpass_output_checker #(int DEPTH = 1024, int SBITS = 24);

   typedef struct packed {
      logic [SBITS-1:0] sample_out;
      logic             saturated;
   } allpass_output_type;

   allpass_output_type       expected_outputs[$];
   logic signed [SBITS-1:0]  x_hist[DEPTH];
   logic signed [SBITS-1:0]  y_hist[DEPTH];
   int unsigned              tap_pos;
   sap_pkg::coef_type        b0, b1, a1;
   logic [sap_pkg::LEN_BITS-1:0] len_reg;
   int                       errors;

   function new();
      clear_history();
      b0 = '0;
      b1 = '0;
      a1 = '0;
      len_reg = sap_pkg::LEN_BITS'(sap_pkg::LEN_MIN);
      errors = 0;
   endfunction

   function void clear_history();
      foreach (x_hist[i]) begin
         x_hist[i] = '0;
         y_hist[i] = '0;
      end
      tap_pos = 0;
   endfunction

   function longint tap(sap_pkg::coef_type c, logic signed [SBITS-1:0] s);
      return longint'(c) * longint'(s);
   endfunction

   function void set_register(sap_pkg::reg_index_type idx, logic [31:0] value);
      case (idx)
         sap_pkg::REG_COEF_B0:      b0 = value[sap_pkg::COEF_BITS-1:0];
         sap_pkg::REG_COEF_B1:      b1 = value[sap_pkg::COEF_BITS-1:0];
         sap_pkg::REG_COEF_A1:      a1 = value[sap_pkg::COEF_BITS-1:0];
         sap_pkg::REG_DELAY_LENGTH: len_reg = value[sap_pkg::LEN_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Run one accepted beat through the filter and queue the output it yields.
   function void note_sample(sap_pkg::op_type op, logic [SBITS-1:0] raw);
      int unsigned     len, p, prv, nxt;
      longint          acc, y, smax, smin;
      logic signed [SBITS-1:0] x;
      allpass_output_type r;
      if (op == sap_pkg::OP_CLEAR) begin
         clear_history();
         return;
      end
      len = len_reg;
      if (len < sap_pkg::LEN_MIN) len = sap_pkg::LEN_MIN;
      if (len > DEPTH) len = DEPTH;
      p   = (tap_pos >= len) ? 0 : tap_pos;
      prv = (p == 0) ? len - 1 : p - 1;
      nxt = (p + 1 >= len) ? 0 : p + 1;
      x   = raw;
      acc = tap(b1, x) + tap(b0, x_hist[prv]) + tap(a1, x_hist[nxt])
          + (longint'(x_hist[p]) <<< sap_pkg::COEF_FRAC)
          - tap(a1, y_hist[prv]) - tap(b0, y_hist[nxt]) - tap(b1, y_hist[p]);
      y = (acc + (longint'(1) <<< (sap_pkg::COEF_FRAC - 1))) >>> sap_pkg::COEF_FRAC;
      smax = (longint'(1) <<< (SBITS - 1)) - 1;
      smin = -smax - 1;
      r.saturated = 1'b0;
      if (y > smax) begin
         y = smax;
         r.saturated = 1'b1;
      end
      if (y < smin) begin
         y = smin;
         r.saturated = 1'b1;
      end
      r.sample_out = y[SBITS-1:0];
      x_hist[p] = x;
      y_hist[p] = r.sample_out;
      tap_pos = nxt;
      expected_outputs.push_back(r);
   endfunction

   function void check_output(logic [SBITS-1:0] data, logic flag);
      allpass_output_type r;
      if (expected_outputs.size() == 0) begin
         $error("unexpected output beat: sample_out %0d saturated %0b", $signed(data), flag);
         errors++;
         return;
      end
      r = expected_outputs.pop_front();
      if (data !== r.sample_out) begin
         $error("sample_out: expected %0d, actual %0d", $signed(r.sample_out), $signed(data));
         errors++;
      end
      if (flag !== r.saturated) begin
         $error("saturated: expected %0b, actual %0b", r.saturated, flag);
         errors++;
      end
   endfunction

   function int outstanding();
      return expected_outputs.size();
   endfunction

endclass

module tb;
   import sap_pkg::*;

   localparam int MAX_LEN       = 1024;
   localparam int SAMPLE_BITS   = 24;
   localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 12;      // a bit over the accept-to-result latency
   localparam int LONG_HOLD     = 400;     // receiver hold-off that backs the block up
   localparam int RANDOM_ITEMS  = 1650;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam coef_type COEF_MAX  = 24'h7FFFFF;
   localparam coef_type COEF_MIN  = 24'h800000;
   localparam coef_type COEF_HALF = 24'h400000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;     // [23:0] sample_in
   logic                  req_tuser;     // [0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;     // [23:0] sample_out
   logic                  rsp_tuser;     // [0] saturated
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   allpass_output_checker #(MAX_LEN, SAMPLE_BITS) sb;

   // Sender burst shaping
   bit gappy;
   int burst_left;

   // Receiver stall pattern and the long hold-off request
   bit long_hold_go;
   int hold_left;
   int stall_mode;
   int mode_left;
   int mode_tick;

   int cycle_count;

   schroeder_allpass_stage_top #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Give up on a hung run; the slowest correct run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: check every output beat at the edge it is taken, then pick the next
   // ready value. A pending long hold-off wins over the pattern; otherwise switch
   // between always-ready, coin-flip, one-in-three and mostly-stalled stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         mode_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_output(rsp_tdata[SAMPLE_BITS-1:0], rsp_tuser);
         if (long_hold_go) begin
            hold_left = LONG_HOLD;
            long_hold_go = 1'b0;
         end
         mode_tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= (mode_tick % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // APB write with a setup phase and an access phase; the register takes the value on the access edge.
   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic write_coef(input reg_index_type idx, input coef_type c);
      write_csr(idx, {{(CSR_DATA_W-COEF_BITS){c[COEF_BITS-1]}}, c});
   endtask

   // Offer one beat and hold it until taken. Between bursts, drop valid for a
   // random gap; within a burst, keep valid high from beat to beat.
   task automatic send_beat(input op_type op, input logic [SAMPLE_BITS-1:0] smp);
      int gap;
      if (gappy && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= DATA_W'(smp);
      do @(posedge clock); while (!req_tready);
      sb.note_sample(op, smp);
   endtask

   // Close the current burst and wait until the block has nothing left in flight.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int v;
      v = $urandom();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return v[0] ? '0 : '1;
         3, 4, 5: begin
            v = int'($urandom_range(0, 4000)) - 2000;
            return v[SAMPLE_BITS-1:0];
         end
         default: return v[SAMPLE_BITS-1:0];
      endcase
   endfunction

   function automatic coef_type pick_coef();
      int v;
      v = $urandom();
      case ($urandom_range(0, 7))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return '0;
         3, 4, 5: begin
            // keep most settings within +-0.5 so the loop stays mostly unclipped
            v = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            return v[COEF_BITS-1:0];
         end
         default: return v[COEF_BITS-1:0];
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_length();
      case ($urandom_range(0, 19))
         0:          return 0;
         1:          return 1;
         2:          return MAX_LEN;
         3:          return MAX_LEN + 1;
         4:          return (1 << LEN_BITS) - 1;
         5:          return $urandom_range(0, (1 << LEN_BITS) - 1);
         6, 7:       return $urandom_range(65, MAX_LEN - 1);
         8, 9, 10:   return $urandom_range(9, 64);
         default:    return $urandom_range(2, 8);
      endcase
   endfunction

   initial begin
      int n_items;
      int n_phase;
      int phase;
      int k;
      sb = new();
      gappy        = 1'b0;
      burst_left   = 0;
      long_hold_go = 1'b0;
      hold_left    = 0;
      stall_mode   = 0;
      mode_left    = 0;
      mode_tick    = 0;
      cycle_count  = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_FILTER;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme coefficients, a length of zero (acts as two), sample
      // extremes, and a clear in the middle of the stream.
      write_coef(REG_COEF_B0, COEF_MAX);
      write_coef(REG_COEF_B1, COEF_MIN);
      write_coef(REG_COEF_A1, COEF_MAX);
      write_csr(REG_DELAY_LENGTH, 0);
      send_beat(OP_FILTER, S_MAX);
      send_beat(OP_FILTER, S_MIN);
      send_beat(OP_FILTER, '0);
      send_beat(OP_FILTER, '1);
      send_beat(OP_FILTER, 1);
      send_beat(OP_CLEAR, S_MAX);
      send_beat(OP_FILTER, S_MAX);
      send_beat(OP_FILTER, S_MIN);
      wait_drained();

      // Opposite extremes, length of one (also acts as two).
      write_coef(REG_COEF_B0, COEF_MIN);
      write_coef(REG_COEF_B1, COEF_MAX);
      write_coef(REG_COEF_A1, COEF_MIN);
      write_csr(REG_DELAY_LENGTH, 1);
      send_beat(OP_FILTER, S_MIN);
      send_beat(OP_FILTER, S_MAX);
      send_beat(OP_FILTER, 24'h400000);
      send_beat(OP_FILTER, '1);
      wait_drained();

      // Walk the position to the end of a length-5 history, then shrink the
      // length so the stored position lies beyond it and must restart at zero.
      write_coef(REG_COEF_B0, COEF_HALF);
      write_coef(REG_COEF_B1, -coef_type'(24'h200000));
      write_coef(REG_COEF_A1, 24'h100000);
      write_csr(REG_DELAY_LENGTH, 5);
      for (k = 0; k < 9; k++)
         send_beat(OP_FILTER, pick_sample());
      wait_drained();
      write_csr(REG_DELAY_LENGTH, 3);
      for (k = 0; k < 3; k++)
         send_beat(OP_FILTER, pick_sample());

      // Random phases: drain, retune, then a stream of samples with rare clears.
      // The second phase runs without sender gaps while the receiver holds off,
      // so the output queue fills and the block stalls its input.
      n_items = 0;
      phase = 0;
      while (n_items < RANDOM_ITEMS) begin
         wait_drained();
         if (phase == 0 || $urandom_range(0, 3) != 0) write_coef(REG_COEF_B0, pick_coef());
         if (phase == 0 || $urandom_range(0, 3) != 0) write_coef(REG_COEF_B1, pick_coef());
         if (phase == 0 || $urandom_range(0, 3) != 0) write_coef(REG_COEF_A1, pick_coef());
         if (phase == 0)
            write_csr(REG_DELAY_LENGTH, (1 << LEN_BITS) - 1);
         else if ($urandom_range(0, 3) != 0)
            write_csr(REG_DELAY_LENGTH, pick_length());
         gappy = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         burst_left = 0;
         if (phase == 1) long_hold_go = 1'b1;
         n_phase = (phase == 1) ? 120 : $urandom_range(20, 150);
         for (k = 0; k < n_phase; k++) begin
            if ($urandom_range(0, 59) == 0)
               send_beat(OP_CLEAR, pick_sample());
            else
               send_beat(OP_FILTER, pick_sample());
         end
         n_items += n_phase;
         phase++;
      end

      wait_drained();
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
